[rtl/pir_pkg.sv]
package pir_pkg;

  localparam int unsigned AtomRowsDefault = 4096;
  localparam int unsigned MaxWrapsDefault = 16;
  localparam int unsigned RowW = 12;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DispW = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_REPAIR = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_XX = 3'd0,
    REG_BOX_YX = 3'd1,
    REG_BOX_YY = 3'd2,
    REG_BOX_ZX = 3'd3,
    REG_BOX_ZY = 3'd4,
    REG_BOX_ZZ = 3'd5
  } reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] xx;
    logic signed [CoordW-1:0] yx;
    logic signed [CoordW-1:0] yy;
    logic signed [CoordW-1:0] zx;
    logic signed [CoordW-1:0] zy;
    logic signed [CoordW-1:0] zz;
  } box_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [RowW-1:0]          first_row;
    logic [RowW-1:0]          second_row;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } req_t;

  typedef struct packed {
    logic [RowW-1:0]          row;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     moved;
    logic                     wrap_overflow;
  } rsp_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [RowW-1:0]          first_row;
    logic [RowW-1:0]          second_row;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } cmd_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CoordW-1:0]  data;
  } cfg_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [DispW-1:0] v);
    logic signed [DispW-1:0] hi;
    logic signed [DispW-1:0] lo;
    hi = DispW'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - DispW'(1);
    if (v > hi) begin
      sat32 = CoordW'(hi);
    end else if (v < lo) begin
      sat32 = CoordW'(lo);
    end else begin
      sat32 = CoordW'(v);
    end
  endfunction

endpackage

[rtl/pir_if.sv]
interface pir_req_if;
  import pir_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pir_rsp_if;
  import pir_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pir_cfg_if;
  import pir_pkg::*;
  logic valid;
  logic ready;
  cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/pir_front.sv]
module pir_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pir_pkg::req_t  in_req_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output pir_pkg::cmd_t  q_cmd_o
);
  import pir_pkg::*;

  // two-entry queue, unused operation dropped here
  cmd_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop, take;

  assign in_ready_o = (cnt_q != 2'd2);
  assign take = in_valid_i && in_ready_o;
  assign push = take && (in_req_i.operation != OP_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cmd_t'(in_req_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("full queue accepts");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("empty queue pointers differ");
endmodule

[rtl/pir_back.sv]
module pir_back #(
  parameter int unsigned ATOM_ROWS = pir_pkg::AtomRowsDefault,
  parameter int unsigned MAX_WRAPS = pir_pkg::MaxWrapsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pir_pkg::box_t box_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  pir_pkg::cmd_t q_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pir_pkg::rsp_t out_rsp_o
);
  import pir_pkg::*;

  localparam int unsigned AW = (ATOM_ROWS > 1) ? $clog2(ATOM_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_WRAPS + 1);
  localparam int unsigned DW = CoordW + CW + 3;
  localparam int unsigned PW = 2 * RowW + 2;
  localparam int unsigned DivSh = RowW + $clog2(ATOM_ROWS);
  localparam int unsigned DivMul =
    int'(((64'd1 << DivSh) + 64'(ATOM_ROWS) - 64'd1) / 64'(ATOM_ROWS));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_WRAP  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_RDOUT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [CoordW-1:0] mem_x [ATOM_ROWS];
  logic [CoordW-1:0] mem_y [ATOM_ROWS];
  logic [CoordW-1:0] mem_z [ATOM_ROWS];

  logic [3:0]        st_q;
  cmd_t              cmd_q;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CoordW-1:0] wx, wy, wz;
  logic signed [CoordW-1:0] rx_q, ry_q, rz_q;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic signed [DW-1:0]     d_q [3];
  logic [1:0]        dim_q;
  logic [CW-1:0]     cnt_q;
  logic              moved_q, ovf_q;
  logic signed [CoordW-1:0] sx_q, sy_q, sz_q;
  rsp_t              rsp_q;
  logic              outv_q;

  // row modulo store depth by reciprocal multiplication
  function automatic logic [AW-1:0] row_idx(input logic [RowW-1:0] r);
    logic [PW-1:0] q;
    logic [PW-1:0] m;
    q = (PW'(r) * PW'(DivMul)) >> DivSh;
    m = PW'(r) - q * PW'(ATOM_ROWS);
    row_idx = AW'(m);
  endfunction

  logic signed [DW-1:0] diag, dk, twod, r0, r1, r2;
  logic pos, neg, skip;

  always_comb begin
    r0 = '0; r1 = '0; r2 = '0;
    case (dim_q)
      2'd2: begin
        r0 = DW'(box_i.zx); r1 = DW'(box_i.zy); r2 = DW'(box_i.zz);
      end
      2'd1: begin
        r0 = DW'(box_i.yx); r1 = DW'(box_i.yy);
      end
      default: begin
        r0 = DW'(box_i.xx);
      end
    endcase
    case (dim_q)
      2'd2: begin diag = r2; dk = d_q[2]; end
      2'd1: begin diag = r1; dk = d_q[1]; end
      default: begin diag = r0; dk = d_q[0]; end
    endcase
    twod = dk <<< 1;
    skip = (diag <= 0);
    pos = twod > diag;
    neg = twod < -diag;
  end

  assign q_ready_o = (st_q == S_IDLE);
  assign out_valid_o = outv_q;
  assign out_rsp_o = rsp_q;

  always_comb begin
    raddr = row_idx(cmd_q.first_row);
    if (st_q == S_RD1 || st_q == S_RD2 || st_q == S_RDOUT || st_q == S_OUT) begin
      raddr = row_idx(cmd_q.second_row);
    end
    if (st_q == S_IDLE) raddr = row_idx(q_cmd_i.first_row);
    if ((st_q == S_RDOUT || st_q == S_OUT) && cmd_q.operation != OP_REPAIR) begin
      raddr = row_idx(cmd_q.first_row);
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = row_idx(cmd_q.first_row);
    wx = cmd_q.in_x; wy = cmd_q.in_y; wz = cmd_q.in_z;
    if (st_q == S_WB) begin
      if (cmd_q.operation == OP_WRITE) begin
        we = 1'b1;
      end else if (moved_q) begin
        we = 1'b1;
        waddr = row_idx(cmd_q.second_row);
        wx = sx_q; wy = sy_q; wz = sz_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
      mem_z[waddr] <= wz;
    end
    rx_q <= mem_x[raddr];
    ry_q <= mem_y[raddr];
    rz_q <= mem_z[raddr];
  end

  logic ovf_s;
  logic signed [DW-1:0] ux, uy, uz;
  logic signed [CoordW-1:0] tx, ty, tz;
  always_comb begin
    ux = DW'(px_q) + d_q[0];
    uy = DW'(py_q) + d_q[1];
    uz = DW'(pz_q) + d_q[2];
    tx = sat32(DispW'(ux));
    ty = sat32(DispW'(uy));
    tz = sat32(DispW'(uz));
    ovf_s = (DW'(tx) != ux) || (DW'(ty) != uy) || (DW'(tz) != uz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      outv_q <= 1'b0;
      dim_q <= 2'd2;
      cnt_q <= '0;
      moved_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      if (st_q == S_OUT && (!outv_q || out_ready_i)) begin
        outv_q <= 1'b1;
      end else if (outv_q && out_ready_i) begin
        outv_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            st_q <= (q_cmd_i.operation == OP_REPAIR) ? S_RD1 : S_WB;
            moved_q <= 1'b0;
            ovf_q <= 1'b0;
          end
        end
        S_RD1: st_q <= S_RD2;
        S_RD2: st_q <= S_DISP;
        S_DISP: begin
          st_q <= S_WRAP;
          dim_q <= 2'd2;
          cnt_q <= '0;
        end
        S_WRAP: begin
          if (!skip && pos && cnt_q != CW'(MAX_WRAPS)) begin
            moved_q <= 1'b1;
            cnt_q <= cnt_q + CW'(1);
          end else if (!skip && neg && cnt_q != CW'(MAX_WRAPS)) begin
            moved_q <= 1'b1;
            cnt_q <= cnt_q + CW'(1);
          end else begin
            if (!skip && (pos || neg)) ovf_q <= 1'b1;
            cnt_q <= '0;
            if (dim_q == 2'd0) st_q <= S_SUM;
            else dim_q <= dim_q - 2'd1;
          end
        end
        S_SUM: begin
          st_q <= S_WB;
          if (moved_q && ovf_s) ovf_q <= 1'b1;
        end
        S_WB: st_q <= S_RDOUT;
        S_RDOUT: st_q <= S_OUT;
        S_OUT: begin
          if (!outv_q || out_ready_i) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) cmd_q <= q_cmd_i;
    if (st_q == S_RD1) begin
      px_q <= rx_q; py_q <= ry_q; pz_q <= rz_q;
    end
    if (st_q == S_DISP) begin
      d_q[0] <= DW'(rx_q) - DW'(px_q);
      d_q[1] <= DW'(ry_q) - DW'(py_q);
      d_q[2] <= DW'(rz_q) - DW'(pz_q);
    end
    if (st_q == S_WRAP && !skip && cnt_q != CW'(MAX_WRAPS)) begin
      if (pos) begin
        d_q[0] <= d_q[0] - r0; d_q[1] <= d_q[1] - r1; d_q[2] <= d_q[2] - r2;
      end else if (neg) begin
        d_q[0] <= d_q[0] + r0; d_q[1] <= d_q[1] + r1; d_q[2] <= d_q[2] + r2;
      end
    end
    if (st_q == S_SUM) begin
      sx_q <= tx; sy_q <= ty; sz_q <= tz;
    end
    if (st_q == S_OUT && (!outv_q || out_ready_i)) begin
      rsp_q.row <= (cmd_q.operation == OP_REPAIR) ? cmd_q.second_row : cmd_q.first_row;
      rsp_q.out_x <= rx_q;
      rsp_q.out_y <= ry_q;
      rsp_q.out_z <= rz_q;
      rsp_q.moved <= moved_q && (cmd_q.operation == OP_REPAIR);
      rsp_q.wrap_overflow <= ovf_q && (cmd_q.operation == OP_REPAIR);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !q_ready_o) else $error("busy back end takes a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WRAP) |-> (cnt_q <= CW'(MAX_WRAPS))) else $error("wrap count exceeded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && cmd_q.operation == OP_REPAIR) |-> moved_q) else $error("unmoved child rewritten");
endmodule

[rtl/periodic_image_repair.sv]
// Periodic image repair over a Q15.16 coordinate store. A front queue of two
// entries accepts requests; the back end runs one request at a time through a
// coordinate memory with one read port and one write port. A write or a read
// passes through the write-back state, the read of the result and the output
// state; a repair first does the two row reads, the displacement and the
// sequential wrap loop over three dimensions (at most MAX_WRAPS shifts per
// dimension) and the sum. A held-off response stalls the back end.
// Box registers are to be written through the configuration channel only while
// the block is idle; the block itself does not enforce this.
module periodic_image_repair #(
  parameter int unsigned ATOM_ROWS = pir_pkg::AtomRowsDefault,
  parameter int unsigned MAX_WRAPS = pir_pkg::MaxWrapsDefault
) (
  input logic    clk_i,
  input logic    rst_ni,
  pir_req_if.sink   in_if,
  pir_rsp_if.source out_if,
  pir_cfg_if.sink   cfg_if
);
  import pir_pkg::*;

  box_t box_q;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.index)
        REG_BOX_XX: box_q.xx <= cfg_if.payload.data;
        REG_BOX_YX: box_q.yx <= cfg_if.payload.data;
        REG_BOX_YY: box_q.yy <= cfg_if.payload.data;
        REG_BOX_ZX: box_q.zx <= cfg_if.payload.data;
        REG_BOX_ZY: box_q.zy <= cfg_if.payload.data;
        REG_BOX_ZZ: box_q.zz <= cfg_if.payload.data;
        default: ;
      endcase
    end
  end

  pir_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_req_i   (in_if.payload),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_cmd_o    (q_cmd)
  );

  pir_back #(.ATOM_ROWS(ATOM_ROWS), .MAX_WRAPS(MAX_WRAPS)) u_back (
    .clk_i, .rst_ni,
    .box_i       (box_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_rsp_o   (out_if.payload)
  );
endmodule

[test/pir_checker.sv]
`timescale 1ns / 100ps

module pir_checker
  import pir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  cfg_t cfg_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o,
  output int   moved_o,
  output int   overflow_o
);

  logic signed [CoordW-1:0] coord_x [AtomRowsDefault];
  logic signed [CoordW-1:0] coord_y [AtomRowsDefault];
  logic signed [CoordW-1:0] coord_z [AtomRowsDefault];
  logic signed [CoordW-1:0] box_reg [6];
  rsp_t expected_q [$];

  function automatic logic signed [CoordW-1:0] clip_coord(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh8000_0000;
    end
    return v[CoordW-1:0];
  endfunction

  function automatic void predict_request(input req_t r);
    rsp_t   e;
    longint b [3][3];
    longint p [3];
    longint d [3];
    logic   mv;
    logic   ovf;
    int     i1;
    int     i2;
    int     k;
    int     j;
    int     cnt;
    e  = '0;
    i1 = int'(r.first_row);
    i2 = int'(r.second_row);
    case (r.operation)
      OP_WRITE: begin
        coord_x[i1] = r.in_x;
        coord_y[i1] = r.in_y;
        coord_z[i1] = r.in_z;
        e.row = r.first_row;
        e.out_x = coord_x[i1];
        e.out_y = coord_y[i1];
        e.out_z = coord_z[i1];
      end
      OP_READ: begin
        e.row = r.first_row;
        e.out_x = coord_x[i1];
        e.out_y = coord_y[i1];
        e.out_z = coord_z[i1];
      end
      OP_REPAIR: begin
        for (k = 0; k < 3; k++) begin
          for (j = 0; j < 3; j++) begin
            b[k][j] = 0;
          end
        end
        b[0][0] = longint'(box_reg[REG_BOX_XX]);
        b[1][0] = longint'(box_reg[REG_BOX_YX]);
        b[1][1] = longint'(box_reg[REG_BOX_YY]);
        b[2][0] = longint'(box_reg[REG_BOX_ZX]);
        b[2][1] = longint'(box_reg[REG_BOX_ZY]);
        b[2][2] = longint'(box_reg[REG_BOX_ZZ]);
        p[0] = longint'(coord_x[i1]);
        p[1] = longint'(coord_y[i1]);
        p[2] = longint'(coord_z[i1]);
        d[0] = longint'(coord_x[i2]) - p[0];
        d[1] = longint'(coord_y[i2]) - p[1];
        d[2] = longint'(coord_z[i2]) - p[2];
        mv  = 1'b0;
        ovf = 1'b0;
        for (k = 2; k >= 0; k--) begin
          if (b[k][k] > 0) begin
            cnt = 0;
            while (2 * d[k] > b[k][k] && cnt < MaxWrapsDefault) begin
              for (j = 0; j <= k; j++) d[j] -= b[k][j];
              mv = 1'b1;
              cnt++;
            end
            while (2 * d[k] < -b[k][k] && cnt < MaxWrapsDefault) begin
              for (j = 0; j <= k; j++) d[j] += b[k][j];
              mv = 1'b1;
              cnt++;
            end
            if (2 * d[k] > b[k][k] || 2 * d[k] < -b[k][k]) ovf = 1'b1;
          end
        end
        if (mv) begin
          coord_x[i2] = clip_coord(p[0] + d[0], ovf);
          coord_y[i2] = clip_coord(p[1] + d[1], ovf);
          coord_z[i2] = clip_coord(p[2] + d[2], ovf);
        end
        e.row = r.second_row;
        e.out_x = coord_x[i2];
        e.out_y = coord_y[i2];
        e.out_z = coord_z[i2];
        e.moved = mv;
        e.wrap_overflow = ovf;
      end
      default: return;
    endcase
    expected_q.insert(expected_q.size(), e);
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      for (int n = 0; n < 6; n++) box_reg[n] = '0;
      mismatches_o = 0;
      checked_o = 0;
      moved_o = 0;
      overflow_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_i.index < 6) begin
        box_reg[cfg_i.index] = cfg_i.data;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) $display("unexpected response: %p", rsp_i);
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          checked_o++;
          if (e.moved) moved_o++;
          if (e.wrap_overflow) overflow_o++;
          if (rsp_i.row !== e.row || rsp_i.out_x !== e.out_x || rsp_i.out_y !== e.out_y ||
              rsp_i.out_z !== e.out_z || rsp_i.moved !== e.moved ||
              rsp_i.wrap_overflow !== e.wrap_overflow) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("mismatch: expected row %0d x %h y %h z %h mv %b ovf %b", e.row,
                       e.out_x, e.out_y, e.out_z, e.moved, e.wrap_overflow);
              $display("          actual   row %0d x %h y %h z %h mv %b ovf %b", rsp_i.row,
                       rsp_i.out_x, rsp_i.out_y, rsp_i.out_z, rsp_i.moved,
                       rsp_i.wrap_overflow);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) predict_request(req_i);
    end
  end

endmodule

[test/tb_periodic_image_repair.sv]
`timescale 1ns / 100ps

module tb_periodic_image_repair;
  import pir_pkg::*;

  localparam int SettleCycles = 100;
  localparam int WatchdogLimit = 20000;
  localparam int NumPhases = 7;
  localparam int ItemsPerPhase = 90;

  logic clk_i;
  logic rst_ni;

  pir_req_if req_if ();
  pir_rsp_if rsp_if ();
  pir_cfg_if cfg_if ();

  int mismatches;
  int pending;
  int checked;
  int moved_cnt;
  int overflow_cnt;
  int quiet_cycles = 0;
  bit written [AtomRowsDefault];
  int written_rows [$];
  logic [CoordW-1:0] box_set [NumPhases][6];
  longint coord_scale;
  bit calm;
  bit hold_trig;

  periodic_image_repair dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if),
    .out_if (rsp_if),
    .cfg_if (cfg_if)
  );

  pir_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_i        (req_if.payload),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_i        (rsp_if.payload),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_i        (cfg_if.payload),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .moved_o      (moved_cnt),
    .overflow_o   (overflow_cnt)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    int r;
    longint v;
    r = $urandom_range(0, 99);
    if (coord_scale > 0 && r < 60) begin
      v = longint'($urandom_range(0, 6 * coord_scale)) - 3 * coord_scale;
      return v[CoordW-1:0];
    end
    if (r < 88) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int g;
    bit held;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_trig && !held) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        g = gap_len();
        if (g == 0) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(input req_t r);
    int g;
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (r.operation == OP_WRITE && !written[r.first_row]) begin
      written[r.first_row] = 1'b1;
      written_rows.insert(written_rows.size(), int'(r.first_row));
    end
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_op(input op_e op, input int r1, input int r2,
                         input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                         input logic [CoordW-1:0] z);
    req_t r;
    r.operation = op;
    r.first_row = RowW'(r1);
    r.second_row = RowW'(r2);
    r.in_x = x;
    r.in_y = y;
    r.in_z = z;
    send(r);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_box(input int ph);
    longint m;
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.payload.index <= reg_e'(i);
      cfg_if.payload.data <= box_set[ph][i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    m = 0;
    for (int i = 0; i < 6; i++) begin
      if ((i == REG_BOX_XX || i == REG_BOX_YY || i == REG_BOX_ZZ) &&
          $signed(box_set[ph][i]) > 0 && (m == 0 || $signed(box_set[ph][i]) < m)) begin
        m = $signed(box_set[ph][i]);
      end
    end
    coord_scale = (m == 0) ? (10 << 16) : ((m > (1 << 28)) ? 0 : m);
  endtask

  task automatic random_item();
    int r;
    int row;
    r = $urandom_range(0, 99);
    if (r < 28 || written_rows.size() < 2) begin
      row = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31) : $urandom_range(0, 4095);
      send_op(OP_WRITE, row, $urandom_range(0, 4095), pick_coord(), pick_coord(),
              pick_coord());
    end else if (r < 80) begin
      send_op(OP_REPAIR, written_rows[$urandom_range(0, written_rows.size() - 1)],
              written_rows[$urandom_range(0, written_rows.size() - 1)], $urandom, $urandom,
              $urandom);
    end else if (r < 95) begin
      send_op(OP_READ, written_rows[$urandom_range(0, written_rows.size() - 1)],
              $urandom_range(0, 4095), $urandom, $urandom, $urandom);
    end else begin
      send_op(OP_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom, $urandom,
              $urandom);
    end
  endtask

  initial begin
    int n;
    box_set[0] = '{32'h000A_0000, 32'h0002_0000, 32'h000A_0000, 32'hFFFD_0000, 32'h0001_0000,
                   32'h000A_0000};
    box_set[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF};
    box_set[2] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    box_set[3] = '{32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h3};
    box_set[4] = '{32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_4000, 32'h0000_C000,
                   32'h0001_0000};
    for (int i = 0; i < 6; i++) box_set[5][i] = $urandom;
    for (int i = 0; i < 6; i++) begin
      box_set[6][i] = (i == 0 || i == 2 || i == 5) ? $urandom_range(1 << 16, 40 << 16)
                                                    : $urandom_range(0, 20 << 16) - (10 << 16);
    end
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    calm = 1'b1;
    hold_trig = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      load_box(ph);
      if (ph == 0) begin
        send_op(OP_WRITE, 0, 4095, 32'h0, 32'h0, 32'h0);
        send_op(OP_WRITE, 4095, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_WRITE, 1, 0, 32'h0013_0000, 32'hFFF0_0000, 32'h0005_8000);
        send_op(OP_WRITE, 2, 0, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000);
        send_op(OP_READ, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_REPAIR, 0, 1, 32'h0, 32'h0, 32'h0);
        send_op(OP_REPAIR, 2, 2, 32'h0, 32'h0, 32'h0);
        send_op(OP_REPAIR, 0, 2, 32'h0, 32'h0, 32'h0);
        send_op(OP_REPAIR, 0, 4095, 32'h0, 32'h0, 32'h0);
        send_op(OP_NONE, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_READ, 1, 0, 32'h0, 32'h0, 32'h0);
      end else if (ph == 1) begin
        send_op(OP_WRITE, 3, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_WRITE, 4, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OP_REPAIR, 3, 4, 32'h0, 32'h0, 32'h0);
        send_op(OP_REPAIR, 4, 3, 32'h0, 32'h0, 32'h0);
        send_op(OP_REPAIR, 4095, 0, 32'h0, 32'h0, 32'h0);
      end else if (ph == 3) begin
        send_op(OP_WRITE, 5, 0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        send_op(OP_REPAIR, 3, 5, 32'h0, 32'h0, 32'h0);
      end
      n = 0;
      while (n < ItemsPerPhase) begin
        calm = ($urandom_range(0, 9) == 0);
        if (ph == 2 && n == 20) hold_trig = 1'b1;
        random_item();
        if (req_if.payload.operation != OP_NONE) n++;
      end
      calm = 1'b0;
      drain();
    end

    $display("ran %0d results over %0d box settings, %0d moved children, %0d overflow flags",
             checked, NumPhases, moved_cnt, overflow_cnt);
    $display("%0d rows written, %0d mismatches", written_rows.size(), mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pir_pkg.sv
rtl/pir_if.sv
rtl/pir_front.sv
rtl/pir_back.sv
rtl/periodic_image_repair.sv
test/pir_checker.sv
test/tb_periodic_image_repair.sv
